>>> rtl/core/prefixed_number_token_parser_unit_assert.svh
// Assertion helpers for the token parser. Each expects clk and rst_n in scope.
`ifndef PREFIXED_NUMBER_TOKEN_PARSER_UNIT_ASSERT_SVH
`define PREFIXED_NUMBER_TOKEN_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PNTP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PNTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pntp_pkg.sv
package pntp_pkg;

  localparam int DEF_VALUE_BITS = 32;
  localparam int BASE_W         = 5;
  localparam int OUT_W          = 32;
  localparam logic [BASE_W-1:0] RESET_BASE = BASE_W'(10);

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic                    is_number;
    logic signed [OUT_W-1:0] number_value;
  } out_req_t;

endpackage

>>> rtl/core/pntp_core.sv
module pntp_core #(
  parameter int VALUE_BITS = pntp_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  pntp_pkg::in_req_t           in_req,
  input  logic [pntp_pkg::BASE_W-1:0] default_base,
  output pntp_pkg::out_req_t          result
);
  import pntp_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [2:0] CNT_MAX   = 3'd4;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_MINUS  = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  // Decode a hex digit character: {valid, value}.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

  logic [2:0]            count_r;
  logic [7:0]            first_r, second_r;
  phase_t                phase_r, phase_c;
  logic [BASE_W-1:0]     base_r, base_c;
  logic                  neg_r, neg_c, seen_r, seen_c, bad_r, bad_c;
  logic [VALUE_BITS-1:0] acc_r, acc_c, val_c;
  logic                  cons_c, lit_c;
  logic [4:0]            dig_c;

  always_comb begin
    phase_c = phase_r;
    base_c  = (count_r == 3'd0) ? default_base : base_r;
    neg_c   = neg_r;
    seen_c  = seen_r;
    bad_c   = bad_r;
    acc_c   = acc_r;
    cons_c  = 1'b0;
    dig_c   = digit_of(in_req.char_code);
    if (!bad_r) begin
      if (phase_c == PH_PREFIX) begin
        phase_c = PH_MINUS;
        case (in_req.char_code)
          CH_PCT: begin
            base_c = BASE_W'(2);
            cons_c = 1'b1;
          end
          CH_HASH: begin
            base_c = BASE_W'(10);
            cons_c = 1'b1;
          end
          CH_DOLLAR: begin
            base_c = BASE_W'(16);
            cons_c = 1'b1;
          end
          default: ;
        endcase
      end
      if (!cons_c && phase_c == PH_MINUS) begin
        phase_c = PH_DIGITS;
        if (in_req.char_code == CH_MINUS) begin
          neg_c  = 1'b1;
          cons_c = 1'b1;
        end
      end
      if (!cons_c && phase_c == PH_DIGITS) begin
        if (!dig_c[4] || BASE_W'(dig_c[3:0]) >= base_c) begin
          bad_c = 1'b1;
        end else begin
          acc_c  = VALUE_BITS'(acc_r * VALUE_BITS'(base_c) + VALUE_BITS'(dig_c[3:0]));
          seen_c = 1'b1;
        end
      end
    end
  end

  assign lit_c = (count_r == 3'd2) && (first_r == CH_QUOTE) && (in_req.char_code == CH_QUOTE);
  assign val_c = neg_c ? VALUE_BITS'(-acc_c) : acc_c;

  always_comb begin
    if (lit_c) begin
      result.is_number    = 1'b1;
      result.number_value = OUT_W'(second_r);
    end else if (!bad_c && seen_c) begin
      result.is_number    = 1'b1;
      result.number_value = OUT_W'(val_c);
    end else begin
      result.is_number    = 1'b0;
      result.number_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && in_req.last_char)) begin
      count_r  <= 3'd0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
      phase_r  <= PH_PREFIX;
      base_r   <= default_base;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      bad_r    <= 1'b0;
      acc_r    <= '0;
    end else if (step) begin
      if (count_r < CNT_MAX) begin
        count_r <= count_r + 3'd1;
      end
      if (count_r == 3'd0) begin
        first_r <= in_req.char_code;
      end
      if (count_r == 3'd1) begin
        second_r <= in_req.char_code;
      end
      phase_r <= phase_c;
      base_r  <= base_c;
      neg_r   <= neg_c;
      seen_r  <= seen_c;
      bad_r   <= bad_c;
      acc_r   <= acc_c;
    end
  end

endmodule

>>> rtl/core/prefixed_number_token_parser_unit.sv
// Prefixed number token parser.
// Input channel (in_valid/in_ready/in_req): one character of a token per request,
// with last_char set on the token's final character. Result channel
// (out_valid/out_ready/out_req): one request per token, issued for its last
// character, carrying is_number and the 32-bit two's complement value.
// Config channel (cfg_valid/cfg_ready/cfg_data): the default base, always ready;
// it is sampled at the first character of each token.
// A final character passes from the input register into the result register;
// a full result register that is not being emptied holds it in the input register.
// Throughput: one character per cycle unless a receiver stall holds the input;
// the per-character work is a single multiply-add (accumulator times a 5-bit base)
// between the input register and the result register.
// Reset (rst_n low, synchronous): both register stages empty, token state
// cleared, default base 10.
// Receiver stall: the result register holds its request; the input register
// keeps draining non-final characters and stops only when a final character
// waits behind a full result register, which then drops in_ready.
`include "prefixed_number_token_parser_unit_assert.svh"

module prefixed_number_token_parser_unit #(
  parameter int VALUE_BITS = pntp_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pntp_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pntp_pkg::out_req_t          out_req,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pntp_pkg::BASE_W-1:0] cfg_data
);
  import pntp_pkg::*;

  logic              s1_valid_r;
  in_req_t           s1_req_r;
  logic              s1_adv;
  logic              out_free;
  logic              out_valid_r;
  out_req_t          out_req_r;
  out_req_t          res;
  logic [BASE_W-1:0] base_r;

  // Config register, written any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= RESET_BASE;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  // Advance the input register when its character produces no result, or
  // when the result register is free or being emptied this cycle.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_req_r.last_char || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r <= in_req;
    end
  end

  // Token state and per-character step.
  pntp_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .in_req      (s1_req_r),
    .default_base(base_r),
    .result      (res)
  );

  // Result register: load on a final character, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_req_r.last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_req_r.last_char) begin
      out_req_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  `PNTP_ASSERT_NEXT(a_last_makes_result, s1_adv && s1_req_r.last_char, out_valid_r,
    "final character did not load the result register")
  `PNTP_ASSERT_IMPLY(a_stall_cause, !in_ready,
    s1_valid_r && s1_req_r.last_char && out_valid_r && !out_ready,
    "input stalled without a blocked final character")
  `PNTP_ASSERT_IMPLY(a_reject_zero, out_valid_r && !out_req_r.is_number,
    out_req_r.number_value == 0, "rejected token carries a nonzero value")

endmodule

>>> test/prefixed_number_token_parser_unit_tb.sv
module prefixed_number_token_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pntp_pkg::*;

  // Character codes the parser treats specially.
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BIN    = 8'h25;  // percent sign, base two
  localparam logic [7:0] CH_DEC    = 8'h23;  // hash, base ten
  localparam logic [7:0] CH_HEX    = 8'h24;  // dollar sign, base sixteen
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPERA = 8'h41;
  localparam logic [7:0] CH_UPPERF = 8'h46;
  localparam logic [7:0] CH_LOWERA = 8'h61;
  localparam logic [7:0] CH_LOWERF = 8'h66;

  localparam logic [BASE_W-1:0] BASE_BIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

  localparam int PHASE_CHARS = 120;
  localparam int SHOW_LIMIT  = 10;

  typedef enum logic [1:0] {
    SCAN_PREFIX,
    SCAN_SIGN,
    SCAN_DIGITS
  } scan_state_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_req_t               in_req = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_req_t              out_req;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BASE_W-1:0]     cfg_data = '0;

  prefixed_number_token_parser_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Characters waiting for the driver, and parsed literals waiting for the monitor.
  in_req_t  pending_chars[$];
  out_req_t expected_literals[$];
  logic [7:0] spelling[$];
  int       chars_issued = 0;
  int       mismatch_count = 0;

  // Shadow of the parser: configured base plus per-token scan state.
  logic [BASE_W-1:0] shadow_default = RESET_BASE;
  logic [2:0]        scan_len = '0;
  logic [7:0]        scan_first = '0;
  logic [7:0]        scan_second = '0;
  scan_state_t       scan_state = SCAN_PREFIX;
  logic [BASE_W-1:0] scan_base = RESET_BASE;
  logic              scan_neg = 1'b0;
  logic              scan_digit = 1'b0;
  logic              scan_bad = 1'b0;
  logic [31:0]       scan_acc = '0;

  // Advance the shadow parser by one character; at the token's end, queue
  // the literal it should produce and clear the scan state.
  function automatic void absorb_char(in_req_t req);
    logic [7:0]        c;
    logic              taken;
    logic              is_glyph;
    logic [BASE_W-1:0] dv;
    logic              quoted;
    out_req_t          lit;
    c = req.char_code;
    taken = 1'b0;
    is_glyph = 1'b0;
    dv = '0;
    if (scan_len == 3'd0) begin
      scan_base = shadow_default;
      scan_first = c;
    end else if (scan_len == 3'd1) begin
      scan_second = c;
    end
    if (!scan_bad) begin
      if (scan_state == SCAN_PREFIX) begin
        scan_state = SCAN_SIGN;
        if (c == CH_BIN) begin
          scan_base = BASE_BIN;
          taken = 1'b1;
        end else if (c == CH_DEC) begin
          scan_base = BASE_DEC;
          taken = 1'b1;
        end else if (c == CH_HEX) begin
          scan_base = BASE_HEX;
          taken = 1'b1;
        end
      end
      if (!taken && scan_state == SCAN_SIGN) begin
        scan_state = SCAN_DIGITS;
        if (c == CH_MINUS) begin
          scan_neg = 1'b1;
          taken = 1'b1;
        end
      end
      if (!taken && scan_state == SCAN_DIGITS) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          dv = BASE_W'(c - CH_ZERO);
          is_glyph = 1'b1;
        end else if (c >= CH_UPPERA && c <= CH_UPPERF) begin
          dv = BASE_W'(c - CH_UPPERA + 8'd10);
          is_glyph = 1'b1;
        end else if (c >= CH_LOWERA && c <= CH_LOWERF) begin
          dv = BASE_W'(c - CH_LOWERA + 8'd10);
          is_glyph = 1'b1;
        end
        // Reject non-digits and digits at or above the base.
        if (!is_glyph || dv >= scan_base) begin
          scan_bad = 1'b1;
        end else begin
          scan_acc = scan_acc * 32'(scan_base) + 32'(dv);
          scan_digit = 1'b1;
        end
      end
    end
    quoted = (scan_len == 3'd2) && (scan_first == CH_QUOTE) && (c == CH_QUOTE);
    if (scan_len < 3'd4) scan_len = scan_len + 3'd1;
    if (req.last_char) begin
      if (quoted) begin
        lit.is_number = 1'b1;
        lit.number_value = {24'd0, scan_second};
      end else if (!scan_bad && scan_digit) begin
        lit.is_number = 1'b1;
        lit.number_value = scan_neg ? 32'd0 - scan_acc : scan_acc;
      end else begin
        lit.is_number = 1'b0;
        lit.number_value = '0;
      end
      expected_literals.push_back(lit);
      scan_len = '0;
      scan_first = '0;
      scan_second = '0;
      scan_state = SCAN_PREFIX;
      scan_base = shadow_default;
      scan_neg = 1'b0;
      scan_digit = 1'b0;
      scan_bad = 1'b0;
      scan_acc = '0;
    end
  endfunction

  // Driver: bursts of back-to-back requests separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_char(in_req);
      // Hold the current request until it is taken.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_chars.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_req <= pending_chars.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(4, 12);
              default: gap_left = $urandom_range(1, 3);
            endcase
          end
        end
      end
    end
  end

  // Monitor: stall the result side in changing patterns and check every
  // accepted result against the oldest pending literal.
  int       stall_mode = 0;
  int       stall_left = 0;
  int       stall_tick = 0;
  out_req_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_literals.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("unexpected result: is_number=%0b value=%0d",
                     out_req.is_number, out_req.number_value);
        end else begin
          want = expected_literals.pop_front();
          if (out_req.is_number !== want.is_number ||
              out_req.number_value !== want.number_value) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
              $display("mismatch: expected is_number=%0b value=%0d, got is_number=%0b value=%0d",
                       want.is_number, want.number_value,
                       out_req.is_number, out_req.number_value);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(5, 60);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= (stall_tick % 5 != 0);
      endcase
    end
  end

  function automatic void emit(logic [7:0] c, logic last);
    in_req_t req;
    req.char_code = c;
    req.last_char = last;
    pending_chars.push_back(req);
    chars_issued++;
  endfunction

  function automatic void emit_text(string s);
    for (int i = 0; i < s.len(); i++) emit(s[i], i == s.len() - 1);
  endfunction

  function automatic void emit_spelling();
    for (int i = 0; i < spelling.size(); i++) emit(spelling[i], i == spelling.size() - 1);
  endfunction

  function automatic logic [7:0] digit_glyph(int v);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? CH_UPPERA : CH_LOWERA) + v - 10);
  endfunction

  // Spell one random token: mostly well-formed numbers and character
  // literals, the rest broken numbers and noise.
  task automatic spell_token();
    int                kind;
    int                ndig;
    int                lim;
    int                v;
    logic [BASE_W-1:0] b;
    kind = $urandom_range(0, 99);
    spelling.delete();
    if (kind < 12) begin
      spelling.push_back(CH_QUOTE);
      spelling.push_back(8'($urandom_range(0, 255)));
      spelling.push_back(CH_QUOTE);
    end else if (kind < 18) begin
      // Near-miss literal: wrong length or missing closing quote.
      spelling.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 3)) spelling.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 26) begin
      repeat ($urandom_range(1, 4)) spelling.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: b = shadow_default;
        1: begin b = BASE_BIN; spelling.push_back(CH_BIN); end
        2: begin b = BASE_DEC; spelling.push_back(CH_DEC); end
        default: begin b = BASE_HEX; spelling.push_back(CH_HEX); end
      endcase
      if ($urandom_range(0, 2) == 0) spelling.push_back(CH_MINUS);
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 34) : $urandom_range(1, 6);
      lim = (b > BASE_HEX) ? 16 : int'(b);
      repeat (ndig) begin
        v = (lim == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim - 1);
        spelling.push_back(digit_glyph(v));
      end
      if (kind >= 88) begin
        case ($urandom_range(0, 2))
          0: spelling[$urandom_range(0, spelling.size() - 1)] = 8'($urandom_range(0, 255));
          1: begin
            spelling.push_back(CH_MINUS);
            spelling.push_back(digit_glyph(0));
          end
          default: begin
            // Prefix or sign, or both, with no digit after them.
            v = spelling.size() - ndig;
            repeat (ndig) void'(spelling.pop_back());
            if (v == 0) spelling.push_back(CH_MINUS);
          end
        endcase
      end
    end
    emit_spelling();
  endtask

  // Wait until every request is taken and every literal checked, then let
  // the pipeline settle.
  task automatic drain();
    while (pending_chars.size() != 0 || in_valid || expected_literals.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_default = v;
  endtask

  logic [BASE_W-1:0] base_plan[$];

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tokens at the reset base of ten.
    emit_text("'A'");
    emit(CH_QUOTE, 1'b0);
    emit(8'hFF, 1'b0);
    emit(CH_QUOTE, 1'b1);
    emit_text("%-101");
    emit_text("$fF");
    emit_text("#9");
    emit_text("-7");
    emit_text("-");
    emit_text("$-");
    emit_text("1-");
    emit_text("%2");
    emit(8'h00, 1'b1);
    drain();

    // Sweep the default base through its extremes and some ordinary values.
    base_plan = '{BASE_BIN, BASE_HEX, BASE_W'(0), BASE_W'(1), BASE_W'(31), BASE_W'(17),
                  BASE_W'($urandom_range(3, 15)), BASE_DEC};
    foreach (base_plan[i]) begin
      write_base(base_plan[i]);
      chars_issued = 0;
      while (chars_issued < PHASE_CHARS) spell_token();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("[prefixed_number_token_parser_unit] OK");
    end else begin
      $display("[prefixed_number_token_parser_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[prefixed_number_token_parser_unit] ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pntp_pkg.sv
rtl/core/pntp_core.sv
rtl/core/prefixed_number_token_parser_unit.sv
test/prefixed_number_token_parser_unit_tb.sv
